@@ sv/tdp_pkg.sv @@
// Package for the trial-division prime test.
// Holds the value widths, the controller/datapath command and status words.
// No dependencies.
package tdp_pkg;

   // Candidate width
   localparam int VALUE_WIDTH = 31;
   // Divisor width: holds floor(sqrt(2^VALUE_WIDTH - 1)) + 1
   localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;
   // Square of the divisor
   localparam int SQ_WIDTH = 2 * DIV_WIDTH;
   // Bit counter for one long division
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam logic [CNT_WIDTH-1:0] STEP_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

   // Controller to datapath
   typedef struct packed {
      logic load;        // take a new candidate, divisor = 2
      logic init_div;    // start a long division by the current divisor
      logic div_step;    // one quotient bit
      logic next_div;    // divisor + 1, square updated
      logic write_res;   // load the result register
      logic res_prime;   // verdict written with write_res
   } tdp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic lt_two;      // candidate below two
      logic sq_gt_n;     // divisor squared exceeds candidate
      logic rem_zero;    // last division left no remainder
      logic step_last;   // current division step is the last one
      logic res_busy;    // result register full and not taken this cycle
   } tdp_sts_type;

endpackage

@@ sv/tdp_ctrl.sv @@
// Controller of the trial-division prime test.
// Sequences the divisor loop and the bit-serial division; uses tdp_pkg.
module tdp_ctrl
   import tdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tdp_sts_type sts,
   output tdp_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_TEST   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      verdict_ff, verdict_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      cmd        = '0;
      cmd.res_prime = verdict_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.lt_two) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (sts.sq_gt_n) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.init_div = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.step_last) state_in = ST_TEST;
         end
         ST_TEST: begin
            if (sts.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // wait for a free result register
            if (!sts.res_busy) begin
               cmd.write_res = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         verdict_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

@@ sv/tdp_dpath.sv @@
// Datapath of the trial-division prime test.
// Candidate, divisor and its square, bit-serial remainder, result register; uses tdp_pkg.
module tdp_dpath
   import tdp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_WIDTH-1:0] req_candidate,
   input  tdp_cmd_type            cmd,
   output tdp_sts_type            sts,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_tested_value,
   output logic                   rsp_is_prime
);

   logic [VALUE_WIDTH-1:0] cand_ff;
   logic [DIV_WIDTH-1:0]   div_ff;
   logic [SQ_WIDTH-1:0]    sq_ff;
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] shr_ff;
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic                   res_valid_ff;
   logic [VALUE_WIDTH-1:0] res_value_ff;
   logic                   res_prime_ff;
   logic [DIV_WIDTH:0]     trial;
   logic [DIV_WIDTH:0]     diff;

   // One restoring-division step: bring down the next bit, subtract if it fits
   assign trial  = {rem_ff, shr_ff[VALUE_WIDTH-1]};
   assign diff   = trial - {1'b0, div_ff};
   assign rem_in = (trial >= {1'b0, div_ff}) ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];

   // Candidate and divisor loop
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cand_ff <= req_candidate;
         div_ff  <= DIV_WIDTH'(2);
         sq_ff   <= SQ_WIDTH'(4);
      end else if (cmd.next_div) begin
         // (d+1)^2 = d^2 + 2d + 1
         div_ff <= div_ff + DIV_WIDTH'(1);
         sq_ff  <= sq_ff + SQ_WIDTH'({div_ff, 1'b1});
      end
   end

   // Bit-serial remainder
   always_ff @(posedge clock) begin
      if (cmd.init_div) begin
         rem_ff <= '0;
         shr_ff <= cand_ff;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         shr_ff <= {shr_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_ff <= cnt_ff + CNT_WIDTH'(1);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (cmd.write_res) begin
         res_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_res) begin
         res_value_ff <= cand_ff;
         res_prime_ff <= cmd.res_prime;
      end
   end

   // Status
   assign sts.lt_two    = (cand_ff < VALUE_WIDTH'(2));
   assign sts.sq_gt_n   = (sq_ff > {{(SQ_WIDTH-VALUE_WIDTH){1'b0}}, cand_ff});
   assign sts.rem_zero  = (rem_ff == '0);
   assign sts.step_last = (cnt_ff == STEP_LAST);
   assign sts.res_busy  = res_valid_ff && !rsp_ready;

   assign rsp_valid        = res_valid_ff;
   assign rsp_tested_value = res_value_ff;
   assign rsp_is_prime     = res_prime_ff;

endmodule

@@ sv/trial_division_prime_test.sv @@
// Top level of the trial-division prime test.
// Joins tdp_ctrl and tdp_dpath; uses tdp_pkg.
//
// Usage:
//   Input channel req_valid/req_ready carries one word: req_candidate, an
//   unsigned value. Result channel rsp_valid/rsp_ready returns one word per
//   candidate: rsp_tested_value (the candidate) and rsp_is_prime.
//   Divisors d = 2, 3, ... are tried while d*d <= candidate; each trial is a
//   bit-serial division, one bit a cycle. One candidate is in work at a
//   time; req_ready is high only while idle, so the next word is taken in
//   the cycle after the result is written at best.
//   The result sits in an output register: a stalled receiver does not hold
//   up the next candidate, which is taken and tested while the previous
//   result waits; only the write of the next result waits for rsp_ready.
//   Reset (synchronous, active high) returns to idle and drops rsp_valid.
module trial_division_prime_test
   import tdp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_candidate,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_tested_value,
   output logic                   rsp_is_prime
);

   tdp_cmd_type cmd;
   tdp_sts_type sts;

   tdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tdp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_candidate    (req_candidate),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_tested_value (rsp_tested_value),
      .rsp_is_prime     (rsp_is_prime)
   );

endmodule

@@ sv/tdp_checker.sv @@
// Port-level checks for the trial-division prime test.
// Bound to trial_division_prime_test; uses tdp_pkg.
module tdp_checker
   import tdp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [VALUE_WIDTH-1:0] req_candidate,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_tested_value,
   input logic                   rsp_is_prime
);

   // A waiting input word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_candidate))
      else $error("input word changed while waiting");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tested_value)
                                  && $stable(rsp_is_prime))
      else $error("result word changed while stalled");

   // Nothing below two is prime
   a_prime_ge_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime |-> rsp_tested_value >= VALUE_WIDTH'(2))
      else $error("value below two reported prime");

   // Two is the only even prime
   a_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime && rsp_tested_value != VALUE_WIDTH'(2)
      |-> rsp_tested_value[0])
      else $error("even value above two reported prime");

   // A taken candidate leaves req_ready low in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after a candidate");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);
